// ===== design/ihdp_pkg.sv =====
// Shared types, constants and helper functions of the image header dimension parser.
package ihdp_pkg;

  typedef enum logic [3:0] {
    PH_SIG0,
    PH_JSOI,
    PH_JMARK,
    PH_JCODE,
    PH_JLENHI,
    PH_JLENLO,
    PH_JSKIP,
    PH_JSOF,
    PH_PNG,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    FMT_UNKNOWN = 2'd0,
    FMT_JPEG    = 2'd1,
    FMT_PNG     = 2'd2
  } format_e;

  localparam logic [7:0] BYTE_FF       = 8'hFF;
  localparam logic [7:0] JPEG_SOI      = 8'hD8;
  localparam logic [7:0] PNG_FIRST     = 8'h89;
  localparam logic [7:0] JPEG_TEM      = 8'h01;
  localparam logic [7:0] JPEG_RST_LO   = 8'hD0;
  localparam logic [7:0] JPEG_RST_HI   = 8'hD9;
  localparam logic [7:0] JPEG_SOF_LO   = 8'hC0;
  localparam logic [7:0] JPEG_SOF_HI   = 8'hCF;
  localparam logic [7:0] JPEG_DHT      = 8'hC4;
  localparam logic [7:0] JPEG_JPG      = 8'hC8;
  localparam logic [7:0] JPEG_DAC      = 8'hCC;

  // Offsets inside a JPEG frame header (counted from its FF) and the PNG header.
  localparam logic [4:0] SOF_START     = 5'd2;
  localparam logic [4:0] SOF_HEIGHT_HI = 5'd5;
  localparam logic [4:0] SOF_HEIGHT_LO = 5'd6;
  localparam logic [4:0] SOF_WIDTH_HI  = 5'd7;
  localparam logic [4:0] SOF_WIDTH_LO  = 5'd8;
  localparam logic [4:0] SOF_END       = 5'd9;
  localparam logic [4:0] PNG_SIG_END   = 5'd8;
  localparam logic [4:0] PNG_TAG_START = 5'd12;
  localparam logic [4:0] PNG_WIDTH_OFS = 5'd16;
  localparam logic [4:0] PNG_HEIGHT_OFS = 5'd20;
  localparam logic [4:0] PNG_END       = 5'd23;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  byte_offset;
    logic [15:0] skip_remaining;
    logic [31:0] width_acc;
    logic [31:0] height_acc;
    logic        answered;
  } state_t;

  typedef struct packed {
    logic        valid;
    format_e     image_format;
    logic [31:0] width_px;
    logic [31:0] height_px;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_SIG0,
    byte_offset:    5'd0,
    skip_remaining: 16'd0,
    width_acc:      32'd0,
    height_acc:     32'd0,
    answered:       1'b0
  };

  localparam result_t RES_UNKNOWN = '{
    valid:        1'b1,
    image_format: FMT_UNKNOWN,
    width_px:     32'd0,
    height_px:    32'd0
  };

  localparam result_t RES_NONE = '{
    valid:        1'b0,
    image_format: FMT_UNKNOWN,
    width_px:     32'd0,
    height_px:    32'd0
  };

  // PNG signature followed by the IHDR chunk header; bytes 8 to 11 are not checked.
  function automatic logic [7:0] png_head_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h89;
      4'd1:    b = 8'h50;
      4'd2:    b = 8'h4E;
      4'd3:    b = 8'h47;
      4'd4:    b = 8'h0D;
      4'd5:    b = 8'h0A;
      4'd6:    b = 8'h1A;
      4'd7:    b = 8'h0A;
      4'd12:   b = 8'h49;
      4'd13:   b = 8'h48;
      4'd14:   b = 8'h44;
      4'd15:   b = 8'h52;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic is_sof(input logic [7:0] c);
    return (c >= JPEG_SOF_LO) && (c <= JPEG_SOF_HI) &&
           (c != JPEG_DHT) && (c != JPEG_JPG) && (c != JPEG_DAC);
  endfunction

  function automatic logic is_standalone(input logic [7:0] c);
    return (c == JPEG_TEM) || ((c >= JPEG_RST_LO) && (c <= JPEG_RST_HI));
  endfunction

endpackage

// ===== design/ihdp_in_if.sv =====
// Byte stream channel into the parser.
interface ihdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== design/ihdp_out_if.sv =====
// Result channel out of the parser.
interface ihdp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  image_format;
  logic [31:0] width_px;
  logic [31:0] height_px;

  modport source (output valid, output image_format, output width_px, output height_px,
                  input ready);
  modport sink   (input valid, input image_format, input width_px, input height_px,
                  output ready);
endinterface

// ===== design/image_header_dimension_parser_unit.sv =====
// Top level of the image header dimension parser: input stage, walk state and result register.
// The settling beat is held in the input stage, and its result is then registered in the result register.
// Throughput: one byte per cycle while no waiting result stalls the walk; the walk state updates once per byte.
// A waiting result stalls the walk; the input stage still takes one byte before ready drops.
// Reset (rst_ni low, asynchronous) empties both stages and rearms the signature check.
module image_header_dimension_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ihdp_in_if.sink    in_i,
  ihdp_out_if.source out_o
);

  logic              stage_v_q;
  logic [7:0]        stage_byte_q;
  logic              stage_last_q;
  ihdp_pkg::state_t  state_q;
  ihdp_pkg::state_t  state_d;
  ihdp_pkg::result_t step_res;
  logic              out_v_q;
  logic [1:0]        out_fmt_q;
  logic [31:0]       out_width_q;
  logic [31:0]       out_height_q;
  logic              advance;
  logic              in_fire;

  assign advance    = stage_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !stage_v_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  ihdp_step u_step (
    .state_i     (state_q),
    .data_byte_i (stage_byte_q),
    .last_byte_i (stage_last_q),
    .state_o     (state_d),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
      state_q   <= ihdp_pkg::STATE_RESET;
      out_v_q   <= 1'b0;
    end else begin
      if (in_fire) stage_v_q <= 1'b1;
      else if (advance) stage_v_q <= 1'b0;
      if (advance) begin
        state_q <= state_d;
        out_v_q <= step_res.valid;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stage_byte_q <= in_i.data_byte;
      stage_last_q <= in_i.last_byte;
    end
    if (advance && step_res.valid) begin
      out_fmt_q    <= step_res.image_format;
      out_width_q  <= step_res.width_px;
      out_height_q <= step_res.height_px;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.image_format = out_fmt_q;
  assign out_o.width_px     = out_width_q;
  assign out_o.height_px    = out_height_q;

endmodule

// ===== design/ihdp_step.sv =====
// Combinational next-state and result logic for one byte of the header walk.
module ihdp_step (
  input  ihdp_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output ihdp_pkg::state_t  state_o,
  output ihdp_pkg::result_t result_o
);

  ihdp_pkg::state_t  nxt;
  ihdp_pkg::result_t res;
  logic [15:0]       seg_len;
  logic [15:0]       skip_dec;
  logic              png_check;
  logic              png_bad;

  assign seg_len   = {state_i.skip_remaining[7:0], data_byte_i};
  assign skip_dec  = state_i.skip_remaining - 16'd1;
  assign png_check = (state_i.byte_offset < ihdp_pkg::PNG_SIG_END) ||
                     ((state_i.byte_offset >= ihdp_pkg::PNG_TAG_START) &&
                      (state_i.byte_offset < ihdp_pkg::PNG_WIDTH_OFS));
  assign png_bad   = png_check &&
                     (data_byte_i != ihdp_pkg::png_head_byte(state_i.byte_offset[3:0]));

  always_comb begin
    nxt = state_i;
    res = ihdp_pkg::RES_NONE;
    case (state_i.phase)
      ihdp_pkg::PH_SIG0: begin
        if (data_byte_i == ihdp_pkg::BYTE_FF) begin
          nxt.phase = ihdp_pkg::PH_JSOI;
        end else if (data_byte_i == ihdp_pkg::PNG_FIRST) begin
          nxt.phase       = ihdp_pkg::PH_PNG;
          nxt.byte_offset = 5'd1;
        end else begin
          res = ihdp_pkg::RES_UNKNOWN;
        end
      end
      ihdp_pkg::PH_JSOI: begin
        if (data_byte_i == ihdp_pkg::JPEG_SOI) nxt.phase = ihdp_pkg::PH_JMARK;
        else res = ihdp_pkg::RES_UNKNOWN;
      end
      ihdp_pkg::PH_JMARK: begin
        if (data_byte_i == ihdp_pkg::BYTE_FF) nxt.phase = ihdp_pkg::PH_JCODE;
        else res = ihdp_pkg::RES_UNKNOWN;
      end
      ihdp_pkg::PH_JCODE: begin
        // A fill byte keeps the walk at the code position.
        if (data_byte_i == ihdp_pkg::BYTE_FF) begin
          nxt.phase = ihdp_pkg::PH_JCODE;
        end else if (ihdp_pkg::is_standalone(data_byte_i)) begin
          nxt.phase = ihdp_pkg::PH_JMARK;
        end else if (ihdp_pkg::is_sof(data_byte_i)) begin
          nxt.phase       = ihdp_pkg::PH_JSOF;
          nxt.byte_offset = ihdp_pkg::SOF_START;
          nxt.width_acc   = 32'd0;
          nxt.height_acc  = 32'd0;
        end else begin
          nxt.phase = ihdp_pkg::PH_JLENHI;
        end
      end
      ihdp_pkg::PH_JLENHI: begin
        nxt.skip_remaining = {8'd0, data_byte_i};
        nxt.phase          = ihdp_pkg::PH_JLENLO;
      end
      ihdp_pkg::PH_JLENLO: begin
        if (seg_len < 16'd2) begin
          res = ihdp_pkg::RES_UNKNOWN;
        end else if (seg_len == 16'd2) begin
          nxt.skip_remaining = 16'd0;
          nxt.phase          = ihdp_pkg::PH_JMARK;
        end else begin
          nxt.skip_remaining = seg_len - 16'd2;
          nxt.phase          = ihdp_pkg::PH_JSKIP;
        end
      end
      ihdp_pkg::PH_JSKIP: begin
        nxt.skip_remaining = skip_dec;
        if (skip_dec == 16'd0) nxt.phase = ihdp_pkg::PH_JMARK;
      end
      ihdp_pkg::PH_JSOF: begin
        if ((state_i.byte_offset == ihdp_pkg::SOF_HEIGHT_HI) ||
            (state_i.byte_offset == ihdp_pkg::SOF_HEIGHT_LO)) begin
          nxt.height_acc = {16'd0, state_i.height_acc[7:0], data_byte_i};
        end else if ((state_i.byte_offset == ihdp_pkg::SOF_WIDTH_HI) ||
                     (state_i.byte_offset == ihdp_pkg::SOF_WIDTH_LO)) begin
          nxt.width_acc = {16'd0, state_i.width_acc[7:0], data_byte_i};
        end
        if (state_i.byte_offset >= ihdp_pkg::SOF_END) begin
          res.valid        = 1'b1;
          res.image_format = ihdp_pkg::FMT_JPEG;
          res.width_px     = nxt.width_acc;
          res.height_px    = nxt.height_acc;
        end else begin
          nxt.byte_offset = state_i.byte_offset + 5'd1;
        end
      end
      ihdp_pkg::PH_PNG: begin
        if (png_bad) begin
          res = ihdp_pkg::RES_UNKNOWN;
        end else begin
          if (!png_check && (state_i.byte_offset >= ihdp_pkg::PNG_WIDTH_OFS) &&
              (state_i.byte_offset < ihdp_pkg::PNG_HEIGHT_OFS)) begin
            nxt.width_acc = {state_i.width_acc[23:0], data_byte_i};
          end else if (state_i.byte_offset >= ihdp_pkg::PNG_HEIGHT_OFS) begin
            nxt.height_acc = {state_i.height_acc[23:0], data_byte_i};
          end
          if (state_i.byte_offset >= ihdp_pkg::PNG_END) begin
            res.valid        = 1'b1;
            res.image_format = ihdp_pkg::FMT_PNG;
            res.width_px     = nxt.width_acc;
            res.height_px    = nxt.height_acc;
          end else begin
            nxt.byte_offset = state_i.byte_offset + 5'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (res.valid) begin
      nxt.answered = 1'b1;
      nxt.phase    = ihdp_pkg::PH_DONE;
    end

    // The last byte always rearms; a stream that never settled reports unknown.
    if (last_byte_i) begin
      if (!res.valid && !state_i.answered) res = ihdp_pkg::RES_UNKNOWN;
      nxt = ihdp_pkg::STATE_RESET;
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// ===== design/ihdp_checker.sv =====
// Port-level checks on the parser top level and the bind that attaches them.
module ihdp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  image_format_i,
  input logic [31:0] width_px_i,
  input logic [31:0] height_px_i
);

  // A waiting result keeps its fields until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(image_format_i) &&
      $stable(width_px_i) && $stable(height_px_i))
    else $error("ihdp: result changed while stalled");

  // An unknown format always reports zero sizes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (image_format_i == ihdp_pkg::FMT_UNKNOWN) |->
      (width_px_i == 32'd0) && (height_px_i == 32'd0))
    else $error("ihdp: unknown format with nonzero size");

  // JPEG frame header sizes are 16-bit fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (image_format_i == ihdp_pkg::FMT_JPEG) |->
      (width_px_i[31:16] == 16'd0) && (height_px_i[31:16] == 16'd0))
    else $error("ihdp: jpeg size wider than 16 bits");

  // A result that appears on an idle output comes from an input beat that passed through the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("ihdp: result without a preceding input beat");

endmodule

bind image_header_dimension_parser_unit ihdp_checker u_ihdp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .image_format_i (out_o.image_format),
  .width_px_i     (out_o.width_px),
  .height_px_i    (out_o.height_px)
);

// ===== tb/sv/ihdp_sniff_sb_pkg.sv =====
// Scoreboard class for the image header dimension parser: byte-level predictor and result check.
package ihdp_sniff_sb_pkg;

  // PNG signature followed by the IHDR tag; offsets 8 to 11 (chunk length) are not compared.
  localparam logic [127:0] PNG_HEAD = 128'h89504E47_0D0A1A0A_00000000_49484452;

  typedef struct {
    ihdp_pkg::format_e fmt;
    logic [31:0]       width;
    logic [31:0]       height;
  } dims_t;

  function automatic logic [7:0] png_head_at(int idx);
    return PNG_HEAD[127 - 8 * idx -: 8];
  endfunction

  function automatic logic starts_frame(logic [7:0] c);
    return (c >= ihdp_pkg::JPEG_SOF_LO) && (c <= ihdp_pkg::JPEG_SOF_HI) &&
           (c != ihdp_pkg::JPEG_DHT) && (c != ihdp_pkg::JPEG_JPG) &&
           (c != ihdp_pkg::JPEG_DAC);
  endfunction

  function automatic logic has_no_body(logic [7:0] c);
    return (c == ihdp_pkg::JPEG_TEM) ||
           ((c >= ihdp_pkg::JPEG_RST_LO) && (c <= ihdp_pkg::JPEG_RST_HI));
  endfunction

  class dimension_scoreboard;
    ihdp_pkg::phase_e walk;
    logic [4:0]       hdr_ofs;
    logic [15:0]      skip_left;
    logic [31:0]      width_sum;
    logic [31:0]      height_sum;
    bit               settled;
    dims_t            expected_dims[$];
    int               mismatches;

    function new();
      mismatches = 0;
      rearm();
    endfunction

    function void rearm();
      walk       = ihdp_pkg::PH_SIG0;
      hdr_ofs    = '0;
      skip_left  = '0;
      width_sum  = '0;
      height_sum = '0;
      settled    = 1'b0;
    endfunction

    function void settle(ihdp_pkg::format_e f, logic [31:0] w, logic [31:0] h);
      dims_t d;
      d.fmt    = f;
      d.width  = w;
      d.height = h;
      expected_dims = {expected_dims, d};
      settled = 1'b1;
      walk    = ihdp_pkg::PH_DONE;
    endfunction

    function int pending();
      return expected_dims.size();
    endfunction

    // Advances the header walk by one accepted beat and queues the answer it settles.
    function void note_byte(logic [7:0] b, logic lst);
      logic [15:0] seg_len;
      logic        fixed_byte;
      case (walk)
        ihdp_pkg::PH_SIG0: begin
          if (b == ihdp_pkg::BYTE_FF) begin
            walk = ihdp_pkg::PH_JSOI;
          end else if (b == ihdp_pkg::PNG_FIRST) begin
            walk    = ihdp_pkg::PH_PNG;
            hdr_ofs = 5'd1;
          end else begin
            settle(ihdp_pkg::FMT_UNKNOWN, '0, '0);
          end
        end
        ihdp_pkg::PH_JSOI: begin
          if (b == ihdp_pkg::JPEG_SOI) walk = ihdp_pkg::PH_JMARK;
          else settle(ihdp_pkg::FMT_UNKNOWN, '0, '0);
        end
        ihdp_pkg::PH_JMARK: begin
          if (b == ihdp_pkg::BYTE_FF) walk = ihdp_pkg::PH_JCODE;
          else settle(ihdp_pkg::FMT_UNKNOWN, '0, '0);
        end
        ihdp_pkg::PH_JCODE: begin
          // A fill byte simply becomes the new marker position.
          if (b == ihdp_pkg::BYTE_FF) begin
            walk = ihdp_pkg::PH_JCODE;
          end else if (has_no_body(b)) begin
            walk = ihdp_pkg::PH_JMARK;
          end else if (starts_frame(b)) begin
            walk       = ihdp_pkg::PH_JSOF;
            hdr_ofs    = ihdp_pkg::SOF_START;
            width_sum  = '0;
            height_sum = '0;
          end else begin
            walk = ihdp_pkg::PH_JLENHI;
          end
        end
        ihdp_pkg::PH_JLENHI: begin
          skip_left = {8'd0, b};
          walk      = ihdp_pkg::PH_JLENLO;
        end
        ihdp_pkg::PH_JLENLO: begin
          seg_len = {skip_left[7:0], b};
          if (seg_len < 16'd2) begin
            settle(ihdp_pkg::FMT_UNKNOWN, '0, '0);
          end else if (seg_len == 16'd2) begin
            skip_left = '0;
            walk      = ihdp_pkg::PH_JMARK;
          end else begin
            skip_left = seg_len - 16'd2;
            walk      = ihdp_pkg::PH_JSKIP;
          end
        end
        ihdp_pkg::PH_JSKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == '0) walk = ihdp_pkg::PH_JMARK;
        end
        ihdp_pkg::PH_JSOF: begin
          if (hdr_ofs == ihdp_pkg::SOF_HEIGHT_HI ||
              hdr_ofs == ihdp_pkg::SOF_HEIGHT_LO) begin
            height_sum = {16'd0, height_sum[7:0], b};
          end else if (hdr_ofs == ihdp_pkg::SOF_WIDTH_HI ||
                       hdr_ofs == ihdp_pkg::SOF_WIDTH_LO) begin
            width_sum = {16'd0, width_sum[7:0], b};
          end
          if (hdr_ofs >= ihdp_pkg::SOF_END) settle(ihdp_pkg::FMT_JPEG, width_sum, height_sum);
          else hdr_ofs = hdr_ofs + 5'd1;
        end
        ihdp_pkg::PH_PNG: begin
          fixed_byte = (hdr_ofs < ihdp_pkg::PNG_SIG_END) ||
                       (hdr_ofs >= ihdp_pkg::PNG_TAG_START &&
                        hdr_ofs < ihdp_pkg::PNG_WIDTH_OFS);
          if (fixed_byte && b != png_head_at(int'(hdr_ofs))) begin
            settle(ihdp_pkg::FMT_UNKNOWN, '0, '0);
          end else begin
            if (hdr_ofs >= ihdp_pkg::PNG_HEIGHT_OFS) height_sum = {height_sum[23:0], b};
            else if (hdr_ofs >= ihdp_pkg::PNG_WIDTH_OFS) width_sum = {width_sum[23:0], b};
            if (hdr_ofs >= ihdp_pkg::PNG_END) settle(ihdp_pkg::FMT_PNG, width_sum, height_sum);
            else hdr_ofs = hdr_ofs + 5'd1;
          end
        end
        default: begin
        end
      endcase
      // A stream that ends before its answer reports unknown; either way the walk rearms.
      if (lst) begin
        if (!settled) settle(ihdp_pkg::FMT_UNKNOWN, '0, '0);
        rearm();
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [1:0] f, logic [31:0] w, logic [31:0] h);
      dims_t d;
      if (expected_dims.size() == 0) begin
        report_mismatch($sformatf("unexpected result format %0d width %0d height %0d",
                                  f, w, h));
        return;
      end
      d = expected_dims.pop_front();
      if (f !== d.fmt)
        report_mismatch($sformatf("image_format got %0d want %0d", f, d.fmt));
      if (w !== d.width)
        report_mismatch($sformatf("width_px got %0d want %0d", w, d.width));
      if (h !== d.height)
        report_mismatch($sformatf("height_px got %0d want %0d", h, d.height));
    endtask
  endclass

endpackage

// ===== tb/sv/tb_image_header_dimension_parser_unit.sv =====
// Testbench top: drives JPEG, PNG and malformed byte streams into the parser and checks each answer.
module tb_image_header_dimension_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int PHASE_BYTES = 165;
  localparam int PHASE_FILES = 4;
  localparam logic [7:0] APP0_CODE = 8'hE0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  int src_idle_pct = 32;
  int snk_idle_pct = 79;
  int cycle_count = 0;
  int bytes_sent;
  int files_sent;

  logic [7:0] file_q[$];
  ihdp_sniff_sb_pkg::dimension_scoreboard dims_sb;

  ihdp_in_if  in_ch();
  ihdp_out_if out_ch();

  image_header_dimension_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (rst_ni) begin
      if (in_ch.valid && in_ch.ready)
        dims_sb.note_byte(in_ch.data_byte, in_ch.last_byte);
      if (out_ch.valid && out_ch.ready)
        dims_sb.check_result(out_ch.image_format, out_ch.width_px, out_ch.height_px);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(logic [7:0] b, logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.data_byte = b;
    in_ch.last_byte = lst;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    files_sent++;
  endtask

  function automatic void append_byte(logic [7:0] b);
    file_q = {file_q, b};
  endfunction

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void build_jpeg();
    logic [7:0]  code;
    logic [15:0] seg_len;
    logic [15:0] hgt;
    logic [15:0] wid;
    file_q = {ihdp_pkg::BYTE_FF, ihdp_pkg::JPEG_SOI};
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: begin
          // Marker position plus fill bytes, then a restart marker.
          repeat ($urandom_range(2, 4)) append_byte(ihdp_pkg::BYTE_FF);
          append_byte(8'(ihdp_pkg::JPEG_RST_LO + $urandom_range(0, 9)));
        end
        1: begin
          append_byte(ihdp_pkg::BYTE_FF);
          if ($urandom_range(0, 10) == 0) append_byte(ihdp_pkg::JPEG_TEM);
          else append_byte(8'(ihdp_pkg::JPEG_RST_LO + $urandom_range(0, 9)));
        end
        default: begin
          do code = 8'($urandom);
          while (code == ihdp_pkg::BYTE_FF || ihdp_sniff_sb_pkg::has_no_body(code) ||
                 ihdp_sniff_sb_pkg::starts_frame(code));
          seg_len = ($urandom_range(0, 29) == 0) ? 16'($urandom_range(256, 300))
                                                 : 16'($urandom_range(2, 12));
          append_byte(ihdp_pkg::BYTE_FF);
          append_byte(code);
          append_byte(seg_len[15:8]);
          append_byte(seg_len[7:0]);
          repeat (int'(seg_len) - 2) append_byte(8'($urandom));
        end
      endcase
    end
    do code = 8'($urandom_range(ihdp_pkg::JPEG_SOF_LO, ihdp_pkg::JPEG_SOF_HI));
    while (!ihdp_sniff_sb_pkg::starts_frame(code));
    hgt = 16'(pick_dim());
    wid = 16'(pick_dim());
    append_byte(ihdp_pkg::BYTE_FF);
    append_byte(code);
    repeat (3) append_byte(8'($urandom));
    append_byte(hgt[15:8]);
    append_byte(hgt[7:0]);
    append_byte(wid[15:8]);
    append_byte(wid[7:0]);
    repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
  endfunction

  function automatic void build_png();
    logic [31:0] wid;
    logic [31:0] hgt;
    wid = pick_dim();
    hgt = pick_dim();
    file_q = {};
    for (int i = 0; i < 16; i++)
      append_byte((i >= 8 && i < 12) ? 8'($urandom) : ihdp_sniff_sb_pkg::png_head_at(i));
    for (int i = 3; i >= 0; i--) append_byte(wid[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) append_byte(hgt[8 * i +: 8]);
    repeat ($urandom_range(0, 2)) append_byte(8'($urandom));
  endfunction

  // Some well-formed files get one byte overwritten or are cut short.
  function automatic void damage_file();
    int cut;
    case ($urandom_range(0, 9))
      0, 1: file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
      2: begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_random_file();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      build_jpeg();
      damage_file();
    end else if (pick < 80) begin
      build_png();
      damage_file();
    end else begin
      file_q = {};
      repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
    end
    send_file();
  endtask

  initial begin
    dims_sb = new();
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Bad first byte that is also the last one.
    file_q = {8'h00};
    send_file();
    // Stream ends before anything is settled.
    file_q = {ihdp_pkg::BYTE_FF};
    send_file();
    // Wrong second byte, then a trailing byte that must be ignored.
    file_q = {ihdp_pkg::BYTE_FF, 8'h12, 8'h34};
    send_file();
    // Segment length below two.
    file_q = {ihdp_pkg::BYTE_FF, ihdp_pkg::JPEG_SOI, ihdp_pkg::BYTE_FF, APP0_CODE,
              8'h00, 8'h01};
    send_file();
    // Frame header with the largest sizes, answered on the last byte.
    file_q = {ihdp_pkg::BYTE_FF, ihdp_pkg::JPEG_SOI, ihdp_pkg::BYTE_FF,
              ihdp_pkg::JPEG_SOF_LO, 8'h00, 8'h11, 8'h08,
              8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h03};
    send_file();
    // Byte other than FF where a marker belongs.
    file_q = {ihdp_pkg::BYTE_FF, ihdp_pkg::JPEG_SOI, 8'h41};
    send_file();
    // PNG signature broken at its second byte.
    file_q = {ihdp_pkg::PNG_FIRST, 8'h00};
    send_file();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 79 : 0;
      snk_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 32 : 0;
      bytes_sent = 0;
      files_sent = 0;
      while (bytes_sent < PHASE_BYTES || files_sent < PHASE_FILES) send_random_file();
      // Hold the source back until every pending answer has been delivered.
      in_ch.valid = 1'b0;
      while (dims_sb.pending() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (dims_sb.mismatches == 0 && dims_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
